### src/nes_pkg.sv
// Package for the NAT endpoint selector: item structs, codes and FSM state type.
// No dependencies; imported by nat_endpoint_selector_top.
package nes_pkg;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  entry_index;
      logic [31:0] entry_addr;
      logic [15:0] entry_port;
      logic        entry_down;
      logic [31:0] pkt_hash;
      logic [31:0] src_addr;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [3:0]  chosen_index;
      logic [31:0] nat_addr;
      logic [15:0] nat_port;
      logic [31:0] rule_out;
   } rsp_item_type;

   // outcome codes
   localparam logic [2:0] OUT_NONE  = 3'd0;
   localparam logic [2:0] OUT_SNAT  = 3'd1;
   localparam logic [2:0] OUT_DNAT  = 3'd2;
   localparam logic [2:0] OUT_DROP  = 3'd3;
   localparam logic [2:0] OUT_WRITE = 3'd4;

   // request types
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SELECT = 1'b1;

   // select modes
   localparam logic MODE_RR   = 1'b0;
   localparam logic MODE_HASH = 1'b1;

   // action kinds; both drop codes discard the packet
   localparam logic [1:0] ACT_SNAT    = 2'd0;
   localparam logic [1:0] ACT_DNAT    = 2'd1;
   localparam logic [1:0] ACT_DROP    = 2'd2;
   localparam logic [1:0] ACT_DROP_HI = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_COUNT  = 2'd1;
   localparam logic [1:0] CSR_ACTION = 2'd2;
   localparam logic [1:0] CSR_RULE   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_READ,
      ST_FORM,
      ST_RESULT
   } state_type;

endpackage

### src/nat_endpoint_selector_top.sv
// NAT endpoint selector top level: endpoint table memory, modulo unit, scan FSM.
// Depends on nes_pkg.
//
//   channel  direction  handshake        payload
//   req      in         req_valid/stall  req_item (req_item_type)
//   rsp      out        rsp_valid/stall  rsp_item (rsp_item_type)
//   csr      in         csr_valid/ready  csr_index, csr_data
//
// Write and drop items go from accept straight to the result state. A select item
// runs through the radix-4 modulo unit, the probe loop over the inactive bits, a
// table read and a step that forms the result. One item is worked on at a time.
// Reset is synchronous; all entries come up inactive, no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile.
module nat_endpoint_selector_top
   import nes_pkg::*;
#(
   parameter int MAX_ENDPOINTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int IDX_W = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
   localparam int SW    = (IDX_W > 5) ? IDX_W : 5;
   localparam int WI_W  = (IDX_W > 4) ? IDX_W : 4;

   // config registers
   logic        mode_ff, mode_in;
   logic [4:0]  count_ff, count_in;
   logic [1:0]  action_ff, action_in;
   logic [31:0] rule_ff, rule_in;

   state_type   state_ff, state_in;
   req_item_type item_ff, item_in;
   rsp_item_type res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic [31:0] div_ff, div_in;
   logic [4:0]  rem_ff, rem_in;
   logic [3:0]  step_ff, step_in;
   logic [4:0]  first_ff, first_in;
   logic [SW-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0] probe_ff, probe_in;
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic [3:0]  hint_ff, hint_in;
   logic [MAX_ENDPOINTS-1:0] inact_ff, inact_in;

   // endpoint table: {addr, port}
   logic [47:0] mem [MAX_ENDPOINTS];
   logic [47:0] rd_ff;
   logic        mem_we;
   logic [IDX_W-1:0] mem_waddr;

   logic [4:0]  cnt;
   logic        accept;
   logic        out_free;
   logic [5:0]  t1, t2;
   logic [4:0]  r1, r2;
   logic [SW-1:0] rem_ext;
   logic [SW:0] scan_p1;
   logic [SW-1:0] rr_next;
   logic        rr_ok;
   logic        hash_ok;
   logic        hashed_active;
   logic [WI_W-1:0] widx;
   logic        widx_ok;
   logic [31:0] xip;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // effective endpoint count: 0 reads as 1, clamp to table depth
   always_comb begin
      if (count_ff == 5'd0) begin
         cnt = 5'd1;
      end else if (32'(count_ff) > MAX_ENDPOINTS) begin
         cnt = 5'(MAX_ENDPOINTS);
      end else begin
         cnt = count_ff;
      end
   end

   // two restoring steps of the modulo per cycle
   always_comb begin
      t1 = {rem_ff, div_ff[31]};
      r1 = (t1 >= {1'b0, cnt}) ? 5'(t1 - {1'b0, cnt}) : t1[4:0];
      t2 = {r1, div_ff[30]};
      r2 = (t2 >= {1'b0, cnt}) ? 5'(t2 - {1'b0, cnt}) : t2[4:0];
      rem_ext = SW'(r2);
      hashed_active = !inact_ff[rem_ext[IDX_W-1:0]];
   end

   // probe helpers
   always_comb begin
      scan_p1 = {1'b0, scan_ff} + 1'b1;
      if (probe_ff == '0) begin
         rr_next = SW'(first_ff);
      end else if (scan_p1 == (SW + 1)'(cnt)) begin
         rr_next = '0;
      end else begin
         rr_next = scan_p1[SW-1:0];
      end
      rr_ok   = (32'(scan_ff) < MAX_ENDPOINTS) && !inact_ff[scan_ff[IDX_W-1:0]];
      hash_ok = !inact_ff[scan_ff[IDX_W-1:0]];
      widx    = WI_W'(req_item.entry_index);
      widx_ok = (32'(widx) < MAX_ENDPOINTS);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.req_type == REQ_WRITE || action_ff > ACT_DNAT) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (step_ff == 4'd15) begin
               if (mode_ff == MODE_HASH && hashed_active) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (mode_ff == MODE_RR) begin
               if (rr_ok) begin
                  state_in = ST_READ;
               end else if (probe_ff == IDX_W'(MAX_ENDPOINTS - 1)) begin
                  state_in = ST_RESULT;
               end
            end else if (hash_ok || scan_p1 == (SW + 1)'(cnt)) begin
               state_in = ST_READ;
            end
         end
         ST_READ:   state_in = ST_FORM;
         ST_FORM:   state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      action_in    = action_ff;
      rule_in      = rule_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      first_in     = first_ff;
      scan_in      = scan_ff;
      probe_in     = probe_ff;
      sel_in       = sel_ff;
      hint_in      = hint_ff;
      inact_in     = inact_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      xip          = rd_ff[47:16];

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:   mode_in   = csr_data[0];
            CSR_COUNT:  count_in  = csr_data[4:0];
            CSR_ACTION: action_in = csr_data[1:0];
            CSR_RULE:   rule_in   = csr_data;
            default:    ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_item;
               res_in  = '0;
               rem_in  = '0;
               step_in = '0;
               if (req_item.req_type == REQ_WRITE) begin
                  res_in.outcome = OUT_WRITE;
                  // out of range writes are acknowledged but store nothing
                  if (widx_ok) begin
                     mem_we    = 1'b1;
                     mem_waddr = widx[IDX_W-1:0];
                     inact_in[widx[IDX_W-1:0]] = req_item.entry_down;
                  end
               end else if (action_ff > ACT_DNAT) begin
                  res_in.outcome = OUT_DROP;
               end else if (mode_ff == MODE_HASH) begin
                  div_in = req_item.pkt_hash;
               end else begin
                  div_in = 32'(hint_ff) + 32'd1;
               end
            end
         end
         ST_MOD: begin
            rem_in  = r2;
            div_in  = {div_ff[29:0], 2'b00};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               probe_in = '0;
               if (mode_ff == MODE_HASH) begin
                  sel_in  = rem_ext[IDX_W-1:0];
                  scan_in = '0;
               end else begin
                  first_in = r2;
                  scan_in  = SW'(hint_ff);
               end
            end
         end
         ST_SCAN: begin
            if (mode_ff == MODE_RR) begin
               if (rr_ok) begin
                  sel_in  = scan_ff[IDX_W-1:0];
                  hint_in = rr_next[3:0];
               end else begin
                  scan_in  = rr_next;
                  probe_in = probe_ff + 1'b1;
                  res_in   = '0;
                  res_in.outcome = OUT_NONE;
               end
            end else if (hash_ok) begin
               sel_in = scan_ff[IDX_W-1:0];
            end else begin
               // no active entry below count: hashed entry stays selected
               scan_in = scan_p1[SW-1:0];
            end
         end
         ST_FORM: begin
            if (action_ff == ACT_DNAT && xip == item_ff.src_addr) begin
               xip = '0;
            end
            res_in.outcome      = (action_ff == ACT_DNAT) ? OUT_DNAT : OUT_SNAT;
            res_in.chosen_index = 4'(sel_ff);
            res_in.nat_addr     = xip;
            res_in.nat_port     = rd_ff[15:0];
            res_in.rule_out     = rule_ff;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RR;
         count_ff     <= 5'd1;
         action_ff    <= ACT_DROP;
         rule_ff      <= '0;
         hint_ff      <= '0;
         inact_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         action_ff    <= action_in;
         rule_ff      <= rule_in;
         hint_ff      <= hint_in;
         inact_ff     <= inact_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      first_ff    <= first_in;
      scan_ff     <= scan_in;
      probe_ff    <= probe_in;
      sel_ff      <= sel_in;
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= {item_in.entry_addr, item_in.entry_port};
      end
      rd_ff <= mem[sel_ff];
   end

endmodule
